FILE: hdl/cdq_pkg.sv
// Package for the circular deque: opcodes, status codes, controller states
// and default sizes. It depends on nothing else.
package cdq_pkg;

  localparam int unsigned DepthDefault     = 128;
  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned CapWidth         = 8;
  localparam int unsigned CapResetMax      = 128;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_REAR  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_REAR  = 3'd3,
    OP_QUERY     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } ctrl_state_e;

endpackage

FILE: hdl/cdq_slot_mem.sv
// Slot store of the circular deque: one write port and two registered read
// ports. It depends on nothing else.
module cdq_slot_mem #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned IW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [IW-1:0]         raddr_a_i,
  input  logic [IW-1:0]         raddr_b_i,
  output logic [DATA_WIDTH-1:0] rdata_a_o,
  output logic [DATA_WIDTH-1:0] rdata_b_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_a_q;
  logic [DATA_WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hdl/cdq_ctrl.sv
// Controller of the circular deque: indices, capacity, sequencing of each
// item and the output register. It uses cdq_pkg and drives cdq_slot_mem.
module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned DATA_WIDTH = DataWidthDefault,
  localparam int unsigned IW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            opcode_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [DATA_WIDTH-1:0] front_value_o,
  output logic [DATA_WIDTH-1:0] rear_value_o,
  output logic                  is_empty_o,
  output logic                  is_full_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CapWidth-1:0]   capacity_in_use_i,
  output logic                  mem_we_o,
  output logic [IW-1:0]         mem_waddr_o,
  output logic [DATA_WIDTH-1:0] mem_wdata_o,
  output logic [IW-1:0]         mem_raddr_a_o,
  output logic [IW-1:0]         mem_raddr_b_o,
  input  logic [DATA_WIDTH-1:0] mem_rdata_a_i,
  input  logic [DATA_WIDTH-1:0] mem_rdata_b_i
);

  localparam int unsigned CapReset = (DEPTH < CapResetMax) ? DEPTH : CapResetMax;

  ctrl_state_e           state_q, state_d;
  logic [IW-1:0]         front_q, front_d;
  logic [IW-1:0]         rear_q, rear_d;
  logic                  empty_q, empty_d;
  logic [CW-1:0]         cap_q, cap_d;
  status_e               status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_status_q;
  logic [DATA_WIDTH-1:0] out_front_q;
  logic [DATA_WIDTH-1:0] out_rear_q;
  logic                  out_empty_q;
  logic                  out_full_q;
  logic                  load_out;
  logic                  in_fire;
  logic                  cfg_fire;
  logic                  full;
  logic [IW-1:0]         front_up;
  logic [IW-1:0]         front_down;
  logic [IW-1:0]         rear_up;
  logic [IW-1:0]         rear_down;

  function automatic logic [IW-1:0] step_up(logic [IW-1:0] idx, logic [CW-1:0] cap);
    logic [CW:0] nxt;
    nxt = {1'b0, CW'(idx)} + (CW+1)'(1);
    return (nxt >= {1'b0, cap}) ? '0 : IW'(nxt);
  endfunction

  function automatic logic [IW-1:0] step_down(logic [IW-1:0] idx, logic [CW-1:0] cap);
    return (idx == '0) ? IW'(cap - CW'(1)) : IW'(idx - IW'(1));
  endfunction

  assign front_up   = step_up(front_q, cap_q);
  assign front_down = step_down(front_q, cap_q);
  assign rear_up    = step_up(rear_q, cap_q);
  assign rear_down  = step_down(rear_q, cap_q);
  assign full       = !empty_q && (front_up == rear_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && (state_q == S_IDLE);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign mem_wdata_o   = value_i;
  assign mem_raddr_a_o = front_q;
  assign mem_raddr_b_o = rear_q;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    empty_d     = empty_q;
    cap_d       = cap_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    load_out    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d  = S_READ;
          status_d = ST_OK;
          case (op_e'(opcode_i)) inside
            OP_INS_FRONT, OP_INS_REAR: begin
              if (full) begin
                status_d = ST_OVERFLOW;
              end else if (empty_q) begin
                front_d     = '0;
                rear_d      = '0;
                empty_d     = 1'b0;
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
              end else if (op_e'(opcode_i) == OP_INS_FRONT) begin
                front_d     = front_up;
                mem_we_o    = 1'b1;
                mem_waddr_o = front_up;
              end else begin
                rear_d      = rear_down;
                mem_we_o    = 1'b1;
                mem_waddr_o = rear_down;
              end
            end
            OP_DEL_FRONT, OP_DEL_REAR: begin
              if (empty_q) begin
                status_d = ST_UNDERFLOW;
              end else if (front_q == rear_q) begin
                front_d = '0;
                rear_d  = '0;
                empty_d = 1'b1;
              end else if (op_e'(opcode_i) == OP_DEL_FRONT) begin
                front_d = front_down;
              end else begin
                rear_d = rear_up;
              end
            end
            default: begin
            end
          endcase
        end
        if (cfg_fire) begin
          if (capacity_in_use_i == '0) begin
            cap_d = CW'(1);
          end else if (32'(capacity_in_use_i) > DEPTH) begin
            cap_d = CW'(DEPTH);
          end else begin
            cap_d = CW'(capacity_in_use_i);
          end
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b1;
        end
      end
      S_READ: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      empty_q     <= 1'b1;
      cap_q       <= CW'(CapReset);
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      empty_q     <= empty_d;
      cap_q       <= cap_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= status_q;
      out_front_q  <= empty_q ? '1 : mem_rdata_a_i;
      out_rear_q   <= empty_q ? '1 : mem_rdata_b_i;
      out_empty_q  <= empty_q;
      out_full_q   <= full;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign front_value_o = out_front_q;
  assign rear_value_o  = out_rear_q;
  assign is_empty_o    = out_empty_q;
  assign is_full_o     = out_full_q;

endmodule

FILE: hdl/circular_deque.sv
// Circular deque top level: binds the controller to the slot store.
// It uses cdq_pkg, cdq_ctrl and cdq_slot_mem.
//
// Each input item carries an opcode (insert front, insert rear, delete front,
// delete rear, query) and a value. Every item gives one result item with the
// status, the front and rear values (all ones when empty) and the empty and
// full flags after the operation.
// The input channel is taken while in_stall_o is low. The edge that accepts
// an item updates the indices and writes the slot store; the controller then
// registers the store read of the new front and rear slots (S_READ) and then
// loads the output register (S_RESP). No new item is taken until the result of
// the last one has been loaded into the output register.
// The output register lets a new item enter while a result waits; if the
// receiver keeps out_stall_i high, the following result waits in the
// controller and the input stalls until the register is free.
// Writing capacity_in_use_i (when cfg_ready_o is high) clamps it to
// 1..DEPTH and empties the deque. Reset empties the deque and sets the
// capacity to 128 slots or DEPTH if smaller; store contents are not cleared.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            opcode_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [DATA_WIDTH-1:0] front_value_o,
  output logic [DATA_WIDTH-1:0] rear_value_o,
  output logic                  is_empty_o,
  output logic                  is_full_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CapWidth-1:0]   capacity_in_use_i
);

  localparam int unsigned IW = $clog2(DEPTH);

  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [IW-1:0]         mem_raddr_a;
  logic [IW-1:0]         mem_raddr_b;
  logic [DATA_WIDTH-1:0] mem_rdata_a;
  logic [DATA_WIDTH-1:0] mem_rdata_b;

  cdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .value_i           (value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .front_value_o     (front_value_o),
    .rear_value_o      (rear_value_o),
    .is_empty_o        (is_empty_o),
    .is_full_o         (is_full_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .capacity_in_use_i (capacity_in_use_i),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_raddr_a_o     (mem_raddr_a),
    .mem_raddr_b_o     (mem_raddr_b),
    .mem_rdata_a_i     (mem_rdata_a),
    .mem_rdata_b_i     (mem_rdata_b)
  );

  cdq_slot_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

endmodule

FILE: dv/cdq_checker.sv
`timescale 1ns / 100ps
// Result checker for the circular deque: predicts every result item from the
// accepted operations and capacity writes, and compares in order.
// It depends on cdq_pkg and is instantiated beside the block by tb_circular_deque.
module cdq_checker
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [2:0]            opcode_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [1:0]            status_i,
  input  logic [DATA_WIDTH-1:0] front_value_i,
  input  logic [DATA_WIDTH-1:0] rear_value_i,
  input  logic                  is_empty_i,
  input  logic                  is_full_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CapWidth-1:0]   capacity_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    overflow_count_o,
  output int                    underflow_count_o,
  output int                    full_count_o
);

  typedef struct packed {
    status_e               status;
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] rear;
    logic                  empty;
    logic                  full;
  } deque_view_t;

  logic [DATA_WIDTH-1:0] slots [DEPTH];
  int unsigned           front_idx;
  int unsigned           rear_idx;
  int unsigned           capacity;
  bit                    deque_empty;
  deque_view_t           expected_views [$];
  int                    fails;
  int                    overflows;
  int                    underflows;
  int                    fulls;

  function automatic int unsigned next_slot(input int unsigned idx);
    return (idx + 1 >= capacity) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned prev_slot(input int unsigned idx);
    return (idx == 0) ? capacity - 1 : idx - 1;
  endfunction

  function automatic bit deque_full();
    return !deque_empty && next_slot(front_idx) == rear_idx;
  endfunction

  function automatic deque_view_t apply_op(input logic [2:0] op,
                                           input logic [DATA_WIDTH-1:0] val);
    deque_view_t v;
    v.status = ST_OK;
    case (op)
      OP_INS_FRONT, OP_INS_REAR: begin
        if (deque_full()) begin
          v.status = ST_OVERFLOW;
          overflows++;
        end else if (deque_empty) begin
          front_idx   = 0;
          rear_idx    = 0;
          deque_empty = 1'b0;
          slots[0]    = val;
        end else if (op == OP_INS_FRONT) begin
          front_idx        = next_slot(front_idx);
          slots[front_idx] = val;
        end else begin
          rear_idx        = prev_slot(rear_idx);
          slots[rear_idx] = val;
        end
      end
      OP_DEL_FRONT, OP_DEL_REAR: begin
        if (deque_empty) begin
          v.status = ST_UNDERFLOW;
          underflows++;
        end else if (front_idx == rear_idx) begin
          front_idx   = 0;
          rear_idx    = 0;
          deque_empty = 1'b1;
        end else if (op == OP_DEL_FRONT) begin
          front_idx = prev_slot(front_idx);
        end else begin
          rear_idx = next_slot(rear_idx);
        end
      end
      default: begin
      end
    endcase
    v.empty = deque_empty;
    v.front = deque_empty ? '1 : slots[front_idx];
    v.rear  = deque_empty ? '1 : slots[rear_idx];
    v.full  = deque_full();
    if (v.full) fulls++;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_view_t got;
    deque_view_t want;
    int unsigned cap_req;
    if (!rst_ni) begin
      expected_views.delete();
      front_idx   = 0;
      rear_idx    = 0;
      deque_empty = 1'b1;
      capacity    = (DEPTH < CapResetMax) ? DEPTH : CapResetMax;
      fails       = 0;
      overflows   = 0;
      underflows  = 0;
      fulls       = 0;
      pending_o   <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.status = status_e'(status_i);
        got.front  = front_value_i;
        got.rear   = rear_value_i;
        got.empty  = is_empty_i;
        got.full   = is_full_i;
        if (expected_views.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%t: result item with none expected: status=%0d front=%h rear=%h empty=%b full=%b",
                     $realtime, got.status, got.front, got.rear, got.empty, got.full);
        end else begin
          want = expected_views.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("%t: mismatch: expected status=%0d front=%h rear=%h empty=%b full=%b, got status=%0d front=%h rear=%h empty=%b full=%b",
                       $realtime, want.status, want.front, want.rear, want.empty, want.full,
                       got.status, got.front, got.rear, got.empty, got.full);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        cap_req = capacity_i;
        if (cap_req == 0) cap_req = 1;
        if (cap_req > DEPTH) cap_req = DEPTH;
        capacity    = cap_req;
        front_idx   = 0;
        rear_idx    = 0;
        deque_empty = 1'b1;
      end
      if (in_valid_i && !in_stall_i) expected_views.push_back(apply_op(opcode_i, value_i));
      pending_o    <= expected_views.size();
      fail_count_o <= fails;
    end
  end

  assign overflow_count_o  = overflows;
  assign underflow_count_o = underflows;
  assign full_count_o      = fulls;

endmodule

FILE: dv/tb_circular_deque.sv
`timescale 1ns / 100ps
// Testbench top for circular_deque: drives directed and random deque operations
// and capacity writes with random gaps and stalls, and gives the verdict.
// It depends on cdq_pkg, cdq_checker and the circular_deque RTL.
module tb_circular_deque;
  import cdq_pkg::*;

  localparam int unsigned DEPTH      = DepthDefault;
  localparam int unsigned DATA_WIDTH = DataWidthDefault;
  localparam int          RANDOM_OPS = 1750;
  localparam int          IDLE_LIMIT = 1000;
  localparam logic [2:0]  OP_SPARE_A = 3'd5;
  localparam logic [2:0]  OP_SPARE_B = 3'd6;
  localparam logic [2:0]  OP_LAST    = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            opcode = OP_QUERY;
  logic [DATA_WIDTH-1:0] value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            status;
  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] rear_value;
  logic                  is_empty;
  logic                  is_full;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CapWidth-1:0]   cap_data = '0;

  int fail_count;
  int pending;
  int overflow_count;
  int underflow_count;
  int full_count;
  int ops_sent = 0;
  int random_sent = 0;
  int settings = 1;
  int idle_cycles = 0;
  bit steady = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  circular_deque #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .opcode_i(opcode),
    .value_i(value),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .status_o(status),
    .front_value_o(front_value),
    .rear_value_o(rear_value),
    .is_empty_o(is_empty),
    .is_full_o(is_full),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .capacity_in_use_i(cap_data)
  );

  cdq_checker #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) checker_inst (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_i(in_stall),
    .opcode_i(opcode),
    .value_i(value),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .status_i(status),
    .front_value_i(front_value),
    .rear_value_i(rear_value),
    .is_empty_i(is_empty),
    .is_full_i(is_full),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .capacity_i(cap_data),
    .fail_count_o(fail_count),
    .pending_o(pending),
    .overflow_count_o(overflow_count),
    .underflow_count_o(underflow_count),
    .full_count_o(full_count)
  );

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 33);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles with no item accepted.", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_op(input logic [2:0] op, input logic [DATA_WIDTH-1:0] val);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ops_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapWidth-1:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cap_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return {1'b0, {(DATA_WIDTH - 1){1'b1}}};
      1: return {1'b1, {(DATA_WIDTH - 1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_op(input traffic_mode_e mode);
    int unsigned roll;
    int unsigned noise;
    int unsigned grow;
    roll  = $urandom_range(0, 99);
    noise = (mode == MODE_MIX) ? 10 : 5;
    grow  = (mode == MODE_FILL) ? 85 : (mode == MODE_DRAIN) ? 20 : 55;
    if (roll < noise) return 3'($urandom_range(OP_QUERY, OP_LAST));
    if (roll < grow) return $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_REAR;
    return $urandom_range(0, 1) ? OP_DEL_FRONT : OP_DEL_REAR;
  endfunction

  task automatic run_segment(input traffic_mode_e mode, input int count);
    for (int i = 0; i < count && random_sent < RANDOM_OPS; i++) begin
      steady <= (random_sent >= 800 && random_sent < 1100);
      send_op(pick_op(mode), pick_value());
      random_sent++;
    end
  endtask

  initial begin
    int caps [] = '{1, 0, 2, 255, 3, 7, 129, 5, 16, 128, 200, 4, 31, 64};
    int phase;
    int unsigned cap_raw;
    int unsigned cap_eff;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_op(OP_QUERY, '0);
    send_op(OP_DEL_FRONT, '0);
    send_op(OP_DEL_REAR, '1);
    send_op(OP_INS_REAR, 32'h1234_5678);
    send_op(OP_DEL_REAR, '0);
    send_op(OP_SPARE_A, '1);
    send_op(OP_SPARE_B, '0);
    send_op(OP_LAST, '1);
    write_capacity(8'd2);
    send_op(OP_INS_FRONT, {1'b0, {(DATA_WIDTH - 1){1'b1}}});
    send_op(OP_INS_REAR, {1'b1, {(DATA_WIDTH - 1){1'b0}}});
    send_op(OP_INS_FRONT, '1);
    send_op(OP_INS_REAR, '0);
    send_op(OP_QUERY, '0);
    send_op(OP_DEL_FRONT, '0);
    send_op(OP_DEL_FRONT, '0);
    send_op(OP_DEL_REAR, '0);
    send_op(OP_INS_FRONT, '0);
    send_op(OP_INS_FRONT, '1);
    send_op(OP_DEL_REAR, '0);
    send_op(OP_DEL_REAR, '0);
    send_op(OP_DEL_FRONT, '0);

    phase = 0;
    while (random_sent < RANDOM_OPS) begin
      cap_raw = (phase < caps.size()) ? caps[phase] : $urandom_range(0, 255);
      cap_eff = (cap_raw == 0) ? 1 : (cap_raw > DEPTH) ? DEPTH : cap_raw;
      write_capacity(CapWidth'(cap_raw));
      run_segment(MODE_FILL, 2 * cap_eff + 4);
      run_segment(MODE_DRAIN, 2 * cap_eff + 4);
      run_segment(MODE_MIX, 20);
      phase++;
    end
    steady <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Ran %0d operations over %0d capacity settings.", ops_sent, settings);
    $display("Saw %0d overflows, %0d underflows and %0d results with the deque full.",
             overflow_count, underflow_count, full_count);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/cdq_pkg.sv
hdl/cdq_slot_mem.sv
hdl/cdq_ctrl.sv
hdl/circular_deque.sv
dv/cdq_checker.sv
dv/tb_circular_deque.sv
